// File: hdl/crpi_pkg.sv
`default_nettype none
package crpi_pkg;

  localparam int COORD_W = 32;            // coordinate width, signed Q16.16
  localparam int N_W     = 6;             // width of the points-per-segment register
  localparam int N_MAX   = 32;            // largest usable points per segment
  localparam int N_RESET = 10;            // points per segment after reset
  localparam int PROD1_W = 12;            // j*j, j*N, N*N
  localparam int PROD2_W = 18;            // j^3, j^2*N, j*N^2, N^3
  localparam int CALC_W  = 22;            // signed width for weight arithmetic
  localparam int WGT_W   = 20;            // stored weight width, signed
  localparam int DIV_W   = 17;            // divisor width, up to 2*N^3
  localparam int REM_W   = DIV_W + 1;     // divider partial remainder
  localparam int ACC_W   = 54;            // weighted sum, signed
  localparam int STEP_W  = 6;             // divider step counter

  typedef enum logic [1:0] {
    MODE_SPLINE,
    MODE_LINEAR,
    MODE_DIRECT
  } mode_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_SPL,
    C_SPL_END,
    C_LIN_FIRST,
    C_LIN_IN,
    C_LIN_END,
    C_FINISH
  } ctrl_state_t;

  typedef enum logic [3:0] {
    P_IDLE,
    P_W1,
    P_W2,
    P_W3,
    P_MAC,
    P_PREP,
    P_DIV,
    P_STORE,
    P_OUT
  } dp_phase_t;

  typedef struct packed {
    logic             load;   // capture the incoming control point
    logic             shift;  // push the current point into the window
    logic             issue;  // start one path point
    mode_t            mode;
    logic [1:0]       idx;    // first bank entry for line and copy points
    logic [N_W-1:0]   jj;     // spline step j or line step i
    logic             done;   // final path point of the list
  } dp_cmd_t;

  typedef struct packed {
    logic cmd_ready;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: hdl/crpi_ctrl.sv
`default_nettype none
module crpi_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_list_end,
  output logic                       in_stall,
  input  wire logic [crpi_pkg::N_W-1:0] n_eff,
  output crpi_pkg::dp_cmd_t          cmd,
  input  wire crpi_pkg::dp_stat_t    stat
);
  import crpi_pkg::*;

  ctrl_state_t    state_r, state_nxt;
  logic [N_W-1:0] cnt_r;
  logic [1:0]     seg_r;
  logic [1:0]     k_r;
  logic [1:0]     seen_r;
  logic           last_r;
  logic [1:0]     base_idx;
  logic           n_one;
  logic           n_gt2;
  logic           seg_last;
  logic           ready;

  assign ready    = stat.cmd_ready;
  assign base_idx = 2'(2'd3 - k_r + seg_r);
  assign n_one    = (n_eff == N_W'(1));
  assign n_gt2    = (n_eff > N_W'(2));
  assign seg_last = (seg_r == 2'(k_r - 2'd1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE: begin
        if (in_valid) begin
          if (seen_r == 2'd3) state_nxt = C_SPL;
          else if (in_list_end) state_nxt = C_LIN_FIRST;
          else state_nxt = C_FINISH;
        end
      end
      C_SPL: begin
        if (ready && cnt_r == N_W'(n_eff - N_W'(1))) begin
          state_nxt = last_r ? C_SPL_END : C_FINISH;
        end
      end
      C_SPL_END: begin
        if (ready) state_nxt = C_FINISH;
      end
      C_LIN_FIRST: begin
        if (ready) begin
          if (k_r == 2'd0 || n_one) state_nxt = C_FINISH;
          else if (n_gt2) state_nxt = C_LIN_IN;
          else state_nxt = C_LIN_END;
        end
      end
      C_LIN_IN: begin
        if (ready && cnt_r == N_W'(n_eff - N_W'(2))) state_nxt = C_LIN_END;
      end
      C_LIN_END: begin
        if (ready) begin
          if (seg_last) state_nxt = C_FINISH;
          else if (n_gt2) state_nxt = C_LIN_IN;
          else state_nxt = C_LIN_END;
        end
      end
      C_FINISH: begin
        if (ready) state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mode = MODE_DIRECT;
    in_stall = (state_r != C_IDLE);
    case (state_r)
      C_IDLE: begin
        cmd.load = in_valid;
      end
      C_SPL: begin
        cmd.issue = ready;
        cmd.mode  = MODE_SPLINE;
        cmd.jj    = cnt_r;
      end
      C_SPL_END: begin
        cmd.issue = ready;
        cmd.idx   = 2'd3;
        cmd.done  = 1'b1;
      end
      C_LIN_FIRST: begin
        cmd.issue = ready;
        cmd.idx   = 2'(2'd3 - k_r);
        cmd.done  = (k_r == 2'd0) || n_one;
      end
      C_LIN_IN: begin
        cmd.issue = ready;
        cmd.mode  = MODE_LINEAR;
        cmd.idx   = base_idx;
        cmd.jj    = cnt_r;
      end
      C_LIN_END: begin
        cmd.issue = ready;
        cmd.idx   = 2'(base_idx + 2'd1);
        cmd.done  = seg_last;
      end
      C_FINISH: begin
        cmd.shift = ready && !last_r;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      seen_r  <= 2'd0;
      cnt_r   <= '0;
      seg_r   <= 2'd0;
      k_r     <= 2'd0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        C_IDLE: begin
          if (in_valid) begin
            k_r    <= seen_r;
            last_r <= in_list_end;
            cnt_r  <= '0;
          end
        end
        C_SPL: begin
          if (ready) cnt_r <= N_W'(cnt_r + N_W'(1));
        end
        C_LIN_FIRST: begin
          if (ready) begin
            seg_r <= 2'd0;
            cnt_r <= N_W'(1);
          end
        end
        C_LIN_IN: begin
          if (ready) cnt_r <= N_W'(cnt_r + N_W'(1));
        end
        C_LIN_END: begin
          if (ready) begin
            seg_r <= 2'(seg_r + 2'd1);
            cnt_r <= N_W'(1);
          end
        end
        C_FINISH: begin
          if (ready) begin
            if (last_r) seen_r <= 2'd0;
            else if (seen_r != 2'd3) seen_r <= 2'(seen_r + 2'd1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/crpi_dp.sv
`default_nettype none
module crpi_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic signed [crpi_pkg::COORD_W-1:0] in_point_x,
  input  wire logic signed [crpi_pkg::COORD_W-1:0] in_point_y,
  input  wire logic signed [crpi_pkg::COORD_W-1:0] in_point_z,
  input  wire logic [crpi_pkg::N_W-1:0]      n_eff,
  input  wire crpi_pkg::dp_cmd_t             cmd,
  output crpi_pkg::dp_stat_t                 stat,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [crpi_pkg::COORD_W-1:0] out_x,
  output logic signed [crpi_pkg::COORD_W-1:0] out_y,
  output logic signed [crpi_pkg::COORD_W-1:0] out_z,
  output logic                               out_path_done
);
  import crpi_pkg::*;

  dp_phase_t phase_r, phase_nxt;

  logic [COORD_W-1:0]       win_r [3][3];   // [entry][axis], oldest entry first
  logic [COORD_W-1:0]       cur_r [3];
  mode_t                    mode_r;
  logic [1:0]               idx_r;
  logic [N_W-1:0]           jj_r;
  logic                     done_r;
  logic [PROD1_W-1:0]       j2_r, jn_r, n2_r;
  logic [PROD2_W-1:0]       j3_r, j2n_r, jn2_r, n3_r;
  logic signed [WGT_W-1:0]  w_r [4];
  logic [DIV_W-1:0]         d_r;
  logic [1:0]               axis_r;
  logic [1:0]               term_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     neg_r;
  logic [ACC_W-1:0]         quo_r;
  logic [REM_W-1:0]         rem_r;
  logic [STEP_W-1:0]        step_r;
  logic [COORD_W-1:0]       res_r [3];
  logic                     out_valid_r;

  logic signed [CALC_W-1:0] sj3, sj2n, sjn2, sn3;
  logic signed [CALC_W-1:0] wc [4];
  logic [DIV_W-1:0]         dc;
  logic [N_W-1:0]           n_m1;
  logic [1:0]               bsel;
  logic signed [COORD_W-1:0] bank_v;
  logic signed [COORD_W+WGT_W-1:0] prod;
  logic [ACC_W-1:0]         mag;
  logic [REM_W-1:0]         trial;
  logic [ACC_W-1:0]         limit;
  logic [ACC_W-1:0]         q_sat;
  logic [ACC_W-1:0]         q_signed;
  logic                     out_free;

  assign out_free       = !out_valid_r || !out_stall;
  assign stat.cmd_ready = (phase_r == P_IDLE);
  assign out_valid      = out_valid_r;

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      P_IDLE:  if (cmd.issue) phase_nxt = P_W1;
      P_W1:    phase_nxt = P_W2;
      P_W2:    phase_nxt = P_W3;
      P_W3:    phase_nxt = P_MAC;
      P_MAC:   if (term_r == 2'd3) phase_nxt = P_PREP;
      P_PREP:  phase_nxt = P_DIV;
      P_DIV:   if (step_r == STEP_W'(ACC_W - 1)) phase_nxt = P_STORE;
      P_STORE: phase_nxt = (axis_r == 2'd2) ? P_OUT : P_MAC;
      P_OUT:   if (out_free) phase_nxt = P_IDLE;
      default: phase_nxt = P_IDLE;
    endcase
  end

  // Catmull-Rom weights scaled by 2*N^3, line weights over N-1.
  assign sj3  = $signed({{(CALC_W-PROD2_W){1'b0}}, j3_r});
  assign sj2n = $signed({{(CALC_W-PROD2_W){1'b0}}, j2n_r});
  assign sjn2 = $signed({{(CALC_W-PROD2_W){1'b0}}, jn2_r});
  assign sn3  = $signed({{(CALC_W-PROD2_W){1'b0}}, n3_r});
  assign n_m1 = N_W'(n_eff - N_W'(1));

  always_comb begin
    wc[0] = '0;
    wc[1] = '0;
    wc[2] = '0;
    wc[3] = '0;
    dc    = DIV_W'(1);
    case (mode_r)
      MODE_SPLINE: begin
        wc[0] = (sj2n <<< 1) - sj3 - sjn2;
        wc[1] = (sn3 <<< 1) + sj3 + (sj3 <<< 1) - sj2n - (sj2n <<< 2);
        wc[2] = (sj2n <<< 2) + sjn2 - sj3 - (sj3 <<< 1);
        wc[3] = sj3 - sj2n;
        dc    = DIV_W'(n3_r << 1);
      end
      MODE_LINEAR: begin
        wc[0] = $signed({{(CALC_W-N_W){1'b0}}, N_W'(n_m1 - jj_r)});
        wc[1] = $signed({{(CALC_W-N_W){1'b0}}, jj_r});
        dc    = DIV_W'(n_m1);
      end
      default: begin
        wc[0] = $signed({{(CALC_W-1){1'b0}}, 1'b1});
        dc    = DIV_W'(1);
      end
    endcase
  end

  assign bsel   = (mode_r == MODE_SPLINE) ? term_r : 2'(idx_r + term_r);
  assign bank_v = (bsel == 2'd3) ? $signed(cur_r[axis_r]) : $signed(win_r[bsel][axis_r]);
  assign prod   = bank_v * w_r[term_r];

  assign mag    = ACC_W'((acc_r[ACC_W-1] ? -acc_r : acc_r)) + ACC_W'(d_r >> 1);
  assign trial  = {rem_r[REM_W-2:0], quo_r[ACC_W-1]};
  assign limit  = neg_r ? (ACC_W'(1) << (COORD_W - 1))
                        : ((ACC_W'(1) << (COORD_W - 1)) - ACC_W'(1));
  assign q_sat    = (quo_r > limit) ? limit : quo_r;
  assign q_signed = neg_r ? ACC_W'(-q_sat) : q_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= P_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (phase_r == P_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r[0] <= in_point_x;
      cur_r[1] <= in_point_y;
      cur_r[2] <= in_point_z;
    end
    if (cmd.shift) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= cur_r;
    end
    case (phase_r)
      P_IDLE: begin
        if (cmd.issue) begin
          mode_r <= cmd.mode;
          idx_r  <= cmd.idx;
          jj_r   <= cmd.jj;
          done_r <= cmd.done;
        end
      end
      P_W1: begin
        j2_r <= PROD1_W'(jj_r) * PROD1_W'(jj_r);
        jn_r <= PROD1_W'(jj_r) * PROD1_W'(n_eff);
        n2_r <= PROD1_W'(n_eff) * PROD1_W'(n_eff);
      end
      P_W2: begin
        j3_r  <= PROD2_W'(j2_r) * PROD2_W'(jj_r);
        j2n_r <= PROD2_W'(j2_r) * PROD2_W'(n_eff);
        jn2_r <= PROD2_W'(jn_r) * PROD2_W'(n_eff);
        n3_r  <= PROD2_W'(n2_r) * PROD2_W'(n_eff);
      end
      P_W3: begin
        for (int t = 0; t < 4; t++) w_r[t] <= WGT_W'(wc[t]);
        d_r    <= dc;
        axis_r <= 2'd0;
        term_r <= 2'd0;
        acc_r  <= '0;
      end
      P_MAC: begin
        // Terms with a zero weight are skipped, so window entries that the
        // current list has not written yet never reach the sum.
        if (w_r[term_r] != '0) acc_r <= acc_r + ACC_W'(prod);
        term_r <= 2'(term_r + 2'd1);
      end
      P_PREP: begin
        neg_r  <= acc_r[ACC_W-1];
        quo_r  <= mag;
        rem_r  <= '0;
        step_r <= '0;
      end
      P_DIV: begin
        if (trial >= REM_W'(d_r)) begin
          rem_r <= REM_W'(trial - REM_W'(d_r));
          quo_r <= {quo_r[ACC_W-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[ACC_W-2:0], 1'b0};
        end
        step_r <= STEP_W'(step_r + STEP_W'(1));
      end
      P_STORE: begin
        res_r[axis_r] <= q_signed[COORD_W-1:0];
        axis_r        <= 2'(axis_r + 2'd1);
        term_r        <= 2'd0;
        acc_r         <= '0;
      end
      P_OUT: begin
        if (out_free) begin
          out_x         <= $signed(res_r[0]);
          out_y         <= $signed(res_r[1]);
          out_z         <= $signed(res_r[2]);
          out_path_done <= done_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/catmull_rom_path_interpolator.sv
`default_nettype none
// Uniform Catmull-Rom path interpolator for 3-D points in signed Q16.16.
// Control points come in one per transfer on the in_ channel; from the fourth
// point of a list on, each point yields N spline points on the middle segment
// of the window, and the list's final point (in_list_end high) is appended.
// Lists of two or three points are joined by straight lines instead, and a
// single point passes straight through. out_path_done marks the last path
// point of each list. N is the points_per_segment register at byte address 0
// of the APB-style port (0 acts as 1, values above 32 act as 32); write it
// only while the block is idle.
// Timing: one control point is in work at a time and in_stall stays high
// until its last path point has been produced. For each path point, P_IDLE
// issues it, P_W1, P_W2 and P_W3 build the weights, then for each axis one
// shared multiply-accumulate unit sums the four terms in P_MAC, P_PREP
// prepares the magnitude, a restoring divider settles one quotient bit per
// cycle over the 54-bit sum in P_DIV and P_STORE stores the result; P_OUT
// then moves it to the output register once that register is free.
// A point that produces no path point is only loaded and shifted into the
// window. The output register lets the next path point be computed while a
// finished one waits for its transfer.
module catmull_rom_path_interpolator (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [crpi_pkg::COORD_W-1:0] in_point_x,
  input  wire logic signed [crpi_pkg::COORD_W-1:0] in_point_y,
  input  wire logic signed [crpi_pkg::COORD_W-1:0] in_point_z,
  input  wire logic                               in_list_end,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [crpi_pkg::COORD_W-1:0]     out_x,
  output logic signed [crpi_pkg::COORD_W-1:0]     out_y,
  output logic signed [crpi_pkg::COORD_W-1:0]     out_z,
  output logic                                    out_path_done,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [2:0]                         paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);
  import crpi_pkg::*;

  logic [N_W-1:0] n_r;
  logic [N_W-1:0] n_eff;
  dp_cmd_t        cmd;
  dp_stat_t       stat;

  // The register decodes on the word address; a write elsewhere is ignored.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-N_W){1'b0}}, n_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= N_W'(N_RESET);
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      n_r <= pwdata[N_W-1:0];
    end
  end

  // Out-of-range settings are clamped once here for both controller and datapath.
  always_comb begin
    if (n_r == '0) n_eff = N_W'(1);
    else if (n_r > N_W'(N_MAX)) n_eff = N_W'(N_MAX);
    else n_eff = n_r;
  end

  crpi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_list_end (in_list_end),
    .in_stall    (in_stall),
    .n_eff       (n_eff),
    .cmd         (cmd),
    .stat        (stat)
  );

  crpi_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .n_eff         (n_eff),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_path_done (out_path_done)
  );

endmodule
`default_nettype wire

// File: sim/catmull_rom_path_interpolator_tb.sv
module catmull_rom_path_interpolator_tb;
  import crpi_pkg::*;

  localparam logic [2:0] REG_POINTS_PER_SEG = 3'd0;
  localparam int         CYCLE_LIMIT        = 25000000;
  localparam int         SETTLE_CYCLES      = 400;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFFFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      done;
  } path_pt_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic signed [COORD_W-1:0] in_point_z = '0;
  logic                      in_list_end = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic                      out_path_done;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [2:0]                paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycle_count = 0;

  // Scoreboard: holds its own copy of the window and of N, and turns every
  // accepted control point into the path points the block should produce.
  class path_scoreboard;
    path_pt_t    path_q[$];
    longint      win[3][3];    // [axis][entry], oldest entry first
    int          seen;
    logic [5:0]  seg_reg;
    int          errors;

    function new();
      seen    = 0;
      seg_reg = 6'(N_RESET);
      errors  = 0;
    endfunction

    task report(input string what);
      errors++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Round to nearest with ties away from zero, then saturate to 32 bits.
    function longint round_sat(input longint num, input longint den);
      longint mag;
      longint q;
      longint lim;
      mag = (num < 0) ? -num : num;
      q   = (mag + den / 2) / den;
      lim = (num < 0) ? 64'sd2147483648 : 64'sd2147483647;
      if (q > lim) q = lim;
      return (num < 0) ? -q : q;
    endfunction

    function void push_pt(input longint x, input longint y, input longint z);
      path_pt_t p;
      p.x = x[31:0];
      p.y = y[31:0];
      p.z = z[31:0];
      p.done = 1'b0;
      path_q.insert(path_q.size(), p);
    endfunction

    function void note_point(input logic signed [COORD_W-1:0] px,
                             input logic signed [COORD_W-1:0] py,
                             input logic signed [COORD_W-1:0] pz,
                             input logic last);
      longint cur[3];
      longint pts[3][4];
      longint v[3];
      longint w[4];
      longint n, j, i, den;
      int     before_cnt, k, s, a;
      cur[0] = px;
      cur[1] = py;
      cur[2] = pz;
      n = seg_reg;
      if (n < 1) n = 1;
      if (n > N_MAX) n = N_MAX;
      before_cnt = path_q.size();
      if (seen >= 3) begin
        den = 2 * n * n * n;
        for (j = 0; j < n; j++) begin
          w[0] = -j*j*j + 2*j*j*n - j*n*n;
          w[1] = 3*j*j*j - 5*j*j*n + 2*n*n*n;
          w[2] = -3*j*j*j + 4*j*j*n + j*n*n;
          w[3] = j*j*j - j*j*n;
          for (a = 0; a < 3; a++)
            v[a] = round_sat(w[0]*win[a][0] + w[1]*win[a][1] + w[2]*win[a][2]
                             + w[3]*cur[a], den);
          push_pt(v[0], v[1], v[2]);
        end
        if (last) push_pt(cur[0], cur[1], cur[2]);
      end else if (last) begin
        // Short list: straight lines through the points seen so far.
        k = seen;
        for (a = 0; a < 3; a++) begin
          for (s = 0; s < k; s++) pts[a][s] = win[a][3 - k + s];
          pts[a][k] = cur[a];
        end
        push_pt(pts[0][0], pts[1][0], pts[2][0]);
        for (s = 0; s < k; s++) begin
          for (i = 1; i < n - 1; i++) begin
            for (a = 0; a < 3; a++)
              v[a] = round_sat((n - 1 - i) * pts[a][s] + i * pts[a][s+1], n - 1);
            push_pt(v[0], v[1], v[2]);
          end
          if (n >= 2) push_pt(pts[0][s+1], pts[1][s+1], pts[2][s+1]);
        end
      end
      if (last) begin
        if (path_q.size() > before_cnt) path_q[path_q.size()-1].done = 1'b1;
        seen = 0;
      end else begin
        for (a = 0; a < 3; a++) begin
          win[a][0] = win[a][1];
          win[a][1] = win[a][2];
          win[a][2] = cur[a];
        end
        if (seen < 3) seen++;
      end
    endfunction

    task check(input path_pt_t got);
      path_pt_t exp_pt;
      if (path_q.size() == 0) begin
        report($sformatf("unexpected path point %h %h %h", got.x, got.y, got.z));
      end else begin
        exp_pt = path_q.pop_front();
        if (got.x !== exp_pt.x)
          report($sformatf("x got %h want %h", got.x, exp_pt.x));
        if (got.y !== exp_pt.y)
          report($sformatf("y got %h want %h", got.y, exp_pt.y));
        if (got.z !== exp_pt.z)
          report($sformatf("z got %h want %h", got.z, exp_pt.z));
        if (got.done !== exp_pt.done)
          report($sformatf("path_done got %b want %b", got.done, exp_pt.done));
      end
    endtask
  endclass

  path_scoreboard sb = new();

  catmull_rom_path_interpolator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_list_end(in_list_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_path_done(out_path_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: check every transfer and stall at random. Values read here
  // are the ones present at the clock edge, since the block updates them
  // with nonblocking assignments.
  always @(posedge clk) begin
    path_pt_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.x    = out_x;
      got.y    = out_y;
      got.z    = out_z;
      got.done = out_path_done;
      sb.check(got);
    end
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Write points_per_segment through the setup and access cycles.
  task write_seg_reg(input logic [5:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_POINTS_PER_SEG;
    pwdata  <= {26'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.seg_reg = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one control point, with random gaps in front of it, and hand it to
  // the scoreboard at the edge where the transfer happens.
  task send_point(input logic signed [COORD_W-1:0] px,
                  input logic signed [COORD_W-1:0] py,
                  input logic signed [COORD_W-1:0] pz,
                  input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_point_x  <= px;
    in_point_y  <= py;
    in_point_z  <= pz;
    in_list_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_point(px, py, pz, last);
  endtask

  // Stop sending right after the last transfer and wait until every expected
  // path point has come out, then give the block time to finish any point
  // that yields nothing.
  task drain;
    in_valid <= 1'b0;
    while (sb.path_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Coordinates: mostly moderate values so that the spline is not always
  // saturated, plus full-range and extreme values.
  function logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(5))
      0, 1:    return $urandom;
      2: begin
        case ($urandom_range(3))
          0:       return COORD_MAX;
          1:       return COORD_MIN;
          2:       return '0;
          default: return -1;
        endcase
      end
      default: return $signed($urandom_range(4000000)) - 2000000;
    endcase
  endfunction

  task send_list(input int len);
    for (int p = 0; p < len; p++)
      send_point(pick_coord(), pick_coord(), pick_coord(), p == len - 1);
  endtask

  // One random phase: lists of mixed length until the item count is reached.
  task run_phase(input int target);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(5) == 0) len = $urandom_range(3, 1);
      else len = $urandom_range(8, 4);
      send_list(len);
      sent += len;
    end
  endtask

  initial begin
    logic [5:0] seg_plan[9];
    int         items;
    seg_plan = '{6'd1, 6'd32, 6'd2, 6'd3, 6'd0, 6'd5, 6'd63, 6'd4, 6'd7};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset value of N: a lone point, a two-point and a
    // three-point line, a spline pushed into saturation, and a longer spline.
    send_point(COORD_MAX, COORD_MIN, '0, 1'b1);
    send_point(COORD_MIN, COORD_MAX, -1, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1, 1'b1);
    send_point(32'sh00010000, -32'sh00010000, 32'sh00008000, 1'b0);
    send_point(32'sh00050000, 32'sh00030000, -32'sh00020000, 1'b0);
    send_point(-32'sh00040000, 32'sh00000001, 32'sh7FFF0000, 1'b1);
    send_point(COORD_MIN, COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MIN, COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MAX, COORD_MIN, 1'b1);
    for (int p = 0; p < 5; p++)
      send_point(32'sh00010000 * p, -32'sh00020000 * p + 3, 32'sh00000007 * p,
                 p == 4);
    drain();

    // Random part: every phase writes a new N while the block is idle. The
    // idling pattern changes over the run, ending with no idling at all.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        tx_idle_pct = 29;
        rx_idle_pct = 82;
      end else if (ph < 6) begin
        tx_idle_pct = 82;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_seg_reg(seg_plan[ph]);
      items = (seg_plan[ph] >= 6'd16) ? 8 : 40;
      run_phase(items);
      drain();
    end

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/crpi_pkg.sv
hdl/crpi_ctrl.sv
hdl/crpi_dp.sv
hdl/catmull_rom_path_interpolator.sv
sim/catmull_rom_path_interpolator_tb.sv
